>>> hdl/gha_pkg.sv
// ============================================================================
// gha_pkg
// Shared types and constants of the generational handle allocator.
// ============================================================================
package gha_pkg;

    localparam int DEF_MAX_HANDLES = 1024;
    localparam int DEF_GEN_BITS    = 16;

    localparam logic KIND_CREATE  = 1'b0;
    localparam logic KIND_DESTROY = 1'b1;

    typedef enum logic [1:0] {
        STAT_CREATED   = 2'd0,
        STAT_DESTROYED = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_STALE     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_C_POOL,
        ST_C_GEN,
        ST_D_META,
        ST_D_SWAP,
        ST_D_FIN
    } state_t;

    // Port enables of the two memories.
    typedef struct packed {
        logic pool_rd;
        logic pool_wr;
        logic meta_rd;
        logic meta_wr_pos;
        logic meta_wr_gen;
    } mem_ctrl_t;

endpackage

>>> hdl/gha_store.sv
// ============================================================================
// gha_store
// Pool memory (position -> id) and metadata memory (id -> position and
// generation), each with one write port and one registered read port.
// ============================================================================
module gha_store
    import gha_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_HANDLES,
    parameter int GEN_W = DEF_GEN_BITS
)
(
    input  logic                      clk,
    input  mem_ctrl_t                 ctrl,
    input  logic [$clog2(DEPTH)-1:0]  pool_rd_addr,
    input  logic [$clog2(DEPTH)-1:0]  pool_wr_addr,
    input  logic [$clog2(DEPTH)-1:0]  pool_wr_data,
    input  logic [$clog2(DEPTH)-1:0]  meta_rd_addr,
    input  logic [$clog2(DEPTH)-1:0]  meta_wr_addr,
    input  logic [$clog2(DEPTH)-1:0]  meta_wr_pos,
    input  logic [GEN_W-1:0]          meta_wr_gen,
    output logic [$clog2(DEPTH)-1:0]  pool_rd_data,
    output logic [$clog2(DEPTH)-1:0]  meta_rd_pos,
    output logic [GEN_W-1:0]          meta_rd_gen
);

    localparam int ID_W = $clog2(DEPTH);

    logic [ID_W-1:0]  pool_mem [DEPTH];
    logic [ID_W-1:0]  pos_mem  [DEPTH];
    logic [GEN_W-1:0] gen_mem  [DEPTH];

    logic [ID_W-1:0]  pool_rd_reg;
    logic [ID_W-1:0]  pos_rd_reg;
    logic [GEN_W-1:0] gen_rd_reg;

    // The position and generation fields of one metadata word have their own
    // write enables, so a position update leaves the generation alone.
    always_ff @(posedge clk)
    begin
        if (ctrl.pool_wr)
        begin
            pool_mem[pool_wr_addr] <= pool_wr_data;
        end
        if (ctrl.pool_rd)
        begin
            pool_rd_reg <= pool_mem[pool_rd_addr];
        end
        if (ctrl.meta_wr_pos)
        begin
            pos_mem[meta_wr_addr] <= meta_wr_pos;
        end
        if (ctrl.meta_wr_gen)
        begin
            gen_mem[meta_wr_addr] <= meta_wr_gen;
        end
        if (ctrl.meta_rd)
        begin
            pos_rd_reg <= pos_mem[meta_rd_addr];
            gen_rd_reg <= gen_mem[meta_rd_addr];
        end
    end

    assign pool_rd_data = pool_rd_reg;
    assign meta_rd_pos  = pos_rd_reg;
    assign meta_rd_gen  = gen_rd_reg;

endmodule

>>> hdl/gha_seq.sv
// ============================================================================
// gha_seq
// Sequencer: handshakes, counters, memory access steps and result register.
// ============================================================================
module gha_seq
    import gha_pkg::*;
#(
    parameter int MAX_HANDLES = DEF_MAX_HANDLES,
    parameter int GEN_BITS    = DEF_GEN_BITS
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            kind,
    input  logic [$clog2(MAX_HANDLES)-1:0]  handle_id,
    input  logic [GEN_BITS-1:0]             handle_gen,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      status,
    output logic [$clog2(MAX_HANDLES)-1:0]  out_id,
    output logic [GEN_BITS-1:0]             out_gen,
    output logic [$clog2(MAX_HANDLES+1)-1:0] live_total,
    output mem_ctrl_t                       ctrl,
    output logic [$clog2(MAX_HANDLES)-1:0]  pool_rd_addr,
    output logic [$clog2(MAX_HANDLES)-1:0]  pool_wr_addr,
    output logic [$clog2(MAX_HANDLES)-1:0]  pool_wr_data,
    output logic [$clog2(MAX_HANDLES)-1:0]  meta_rd_addr,
    output logic [$clog2(MAX_HANDLES)-1:0]  meta_wr_addr,
    output logic [$clog2(MAX_HANDLES)-1:0]  meta_wr_pos,
    output logic [GEN_BITS-1:0]             meta_wr_gen,
    input  logic [$clog2(MAX_HANDLES)-1:0]  pool_rd_data,
    input  logic [$clog2(MAX_HANDLES)-1:0]  meta_rd_pos,
    input  logic [GEN_BITS-1:0]             meta_rd_gen
);

    localparam int ID_W    = $clog2(MAX_HANDLES);
    localparam int COUNT_W = $clog2(MAX_HANDLES + 1);

    state_t               state_reg, state_next;
    logic [COUNT_W-1:0]   live_reg, live_next;
    logic [COUNT_W-1:0]   fresh_reg, fresh_next;
    logic                 out_valid_reg, out_valid_next;

    status_t              status_reg, status_next;
    logic [ID_W-1:0]      out_id_reg, out_id_next;
    logic [GEN_BITS-1:0]  out_gen_reg, out_gen_next;
    logic [COUNT_W-1:0]   live_total_reg, live_total_next;
    logic [ID_W-1:0]      hid_reg, hid_next;
    logic [GEN_BITS-1:0]  hgen_reg, hgen_next;
    logic [ID_W-1:0]      id_reg, id_next;
    logic [ID_W-1:0]      pos_reg, pos_next;
    logic [GEN_BITS-1:0]  gen_reg, gen_next;

    logic                 accept;
    logic [COUNT_W-1:0]   live_inc;
    logic [COUNT_W-1:0]   live_dec;
    logic [ID_W-1:0]      last_pos;

    assign in_stall = !(state_reg == ST_IDLE && (!out_valid_reg || !out_stall));
    assign accept   = in_valid && !in_stall;
    assign live_inc = live_reg + COUNT_W'(1);
    assign live_dec = live_reg - COUNT_W'(1);
    assign last_pos = live_dec[ID_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            live_reg      <= '0;
            fresh_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            live_reg      <= live_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg     <= status_next;
        out_id_reg     <= out_id_next;
        out_gen_reg    <= out_gen_next;
        live_total_reg <= live_total_next;
        hid_reg        <= hid_next;
        hgen_reg       <= hgen_next;
        id_reg         <= id_next;
        pos_reg        <= pos_next;
        gen_reg        <= gen_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        live_next       = live_reg;
        fresh_next      = fresh_reg;
        out_valid_next  = out_valid_reg && out_stall;
        status_next     = status_reg;
        out_id_next     = out_id_reg;
        out_gen_next    = out_gen_reg;
        live_total_next = live_total_reg;
        hid_next        = hid_reg;
        hgen_next       = hgen_reg;
        id_next         = id_reg;
        pos_next        = pos_reg;
        gen_next        = gen_reg;
        ctrl            = '0;
        pool_rd_addr    = '0;
        pool_wr_addr    = '0;
        pool_wr_data    = '0;
        meta_rd_addr    = '0;
        meta_wr_addr    = '0;
        meta_wr_pos     = '0;
        meta_wr_gen     = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    hid_next  = handle_id;
                    hgen_next = handle_gen;
                    if (kind == KIND_CREATE)
                    begin
                        if (live_reg < fresh_reg)
                        begin
                            // A dead id waits just past the live section.
                            ctrl.pool_rd = 1'b1;
                            pool_rd_addr = live_reg[ID_W-1:0];
                            state_next   = ST_C_POOL;
                        end
                        else if (fresh_reg < COUNT_W'(MAX_HANDLES))
                        begin
                            ctrl.pool_wr     = 1'b1;
                            ctrl.meta_wr_pos = 1'b1;
                            ctrl.meta_wr_gen = 1'b1;
                            pool_wr_addr     = fresh_reg[ID_W-1:0];
                            pool_wr_data     = fresh_reg[ID_W-1:0];
                            meta_wr_addr     = fresh_reg[ID_W-1:0];
                            meta_wr_pos      = fresh_reg[ID_W-1:0];
                            meta_wr_gen      = '0;
                            fresh_next       = fresh_reg + COUNT_W'(1);
                            live_next        = live_inc;
                            out_valid_next   = 1'b1;
                            status_next      = STAT_CREATED;
                            out_id_next      = fresh_reg[ID_W-1:0];
                            out_gen_next     = '0;
                            live_total_next  = live_inc;
                        end
                        else
                        begin
                            out_valid_next  = 1'b1;
                            status_next     = STAT_FULL;
                            out_id_next     = '0;
                            out_gen_next    = '0;
                            live_total_next = live_reg;
                        end
                    end
                    else
                    begin
                        if (COUNT_W'(handle_id) < fresh_reg)
                        begin
                            ctrl.meta_rd = 1'b1;
                            meta_rd_addr = handle_id;
                            state_next   = ST_D_META;
                        end
                        else
                        begin
                            out_valid_next  = 1'b1;
                            status_next     = STAT_STALE;
                            out_id_next     = '0;
                            out_gen_next    = '0;
                            live_total_next = live_reg;
                        end
                    end
                end
            end

            ST_C_POOL:
            begin
                ctrl.meta_rd = 1'b1;
                meta_rd_addr = pool_rd_data;
                id_next      = pool_rd_data;
                state_next   = ST_C_GEN;
            end

            ST_C_GEN:
            begin
                ctrl.meta_wr_gen = 1'b1;
                meta_wr_addr     = id_reg;
                meta_wr_gen      = meta_rd_gen + GEN_BITS'(1);
                live_next        = live_inc;
                out_valid_next   = 1'b1;
                status_next      = STAT_CREATED;
                out_id_next      = id_reg;
                out_gen_next     = meta_rd_gen + GEN_BITS'(1);
                live_total_next  = live_inc;
                state_next       = ST_IDLE;
            end

            ST_D_META:
            begin
                if (COUNT_W'(meta_rd_pos) < live_reg && meta_rd_gen == hgen_reg)
                begin
                    pos_next     = meta_rd_pos;
                    gen_next     = meta_rd_gen;
                    ctrl.pool_rd = 1'b1;
                    pool_rd_addr = last_pos;
                    state_next   = ST_D_SWAP;
                end
                else
                begin
                    out_valid_next  = 1'b1;
                    status_next     = STAT_STALE;
                    out_id_next     = '0;
                    out_gen_next    = '0;
                    live_total_next = live_reg;
                    state_next      = ST_IDLE;
                end
            end

            ST_D_SWAP:
            begin
                // The last live id moves into the freed slot.
                ctrl.pool_wr     = 1'b1;
                ctrl.meta_wr_pos = 1'b1;
                pool_wr_addr     = pos_reg;
                pool_wr_data     = pool_rd_data;
                meta_wr_addr     = pool_rd_data;
                meta_wr_pos      = pos_reg;
                state_next       = ST_D_FIN;
            end

            ST_D_FIN:
            begin
                ctrl.pool_wr     = 1'b1;
                ctrl.meta_wr_pos = 1'b1;
                ctrl.meta_wr_gen = 1'b1;
                pool_wr_addr     = last_pos;
                pool_wr_data     = hid_reg;
                meta_wr_addr     = hid_reg;
                meta_wr_pos      = last_pos;
                meta_wr_gen      = gen_reg + GEN_BITS'(1);
                live_next        = live_dec;
                out_valid_next   = 1'b1;
                status_next      = STAT_DESTROYED;
                out_id_next      = '0;
                out_gen_next     = '0;
                live_total_next  = live_dec;
                state_next       = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign out_id     = out_id_reg;
    assign out_gen    = out_gen_reg;
    assign live_total = live_total_reg;

endmodule

>>> hdl/generational_handle_allocator.sv
// ============================================================================
// generational_handle_allocator
// Hands out and retires handles made of an id and a generation counter.
// ============================================================================
// Each item either creates a handle or destroys one, and gives exactly one
// result item. A create, a full pool and a destroy whose id was never minted
// are settled in the cycle the item is taken, so such items can follow one
// another every cycle while the result is not stalled. A create that reuses
// a dead id steps through ST_C_POOL and ST_C_GEN: it reads the pool memory
// for the id and then the metadata memory for its generation. A destroy
// ends in ST_D_META when the handle is stale or dead; one that succeeds goes
// on through ST_D_SWAP and ST_D_FIN: one metadata read, one pool read of the
// last live id, and two writes through the single write port of each memory
// for the swap. The pool memory maps positions to ids; the metadata memory
// maps ids to their pool position and generation. Neither memory is cleared
// at reset, because only entries of ids already minted are ever read.
// Generations wrap from all ones to zero. The result sits in a register,
// so the next item can be taken in the cycle the previous result leaves.
// ============================================================================
module generational_handle_allocator
    import gha_pkg::*;
#(
    parameter int MAX_HANDLES = DEF_MAX_HANDLES,
    parameter int GEN_BITS    = DEF_GEN_BITS
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             kind,
    input  logic [$clog2(MAX_HANDLES)-1:0]   handle_id,
    input  logic [GEN_BITS-1:0]              handle_gen,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [1:0]                       status,
    output logic [$clog2(MAX_HANDLES)-1:0]   out_id,
    output logic [GEN_BITS-1:0]              out_gen,
    output logic [$clog2(MAX_HANDLES+1)-1:0] live_total
);

    localparam int ID_W = $clog2(MAX_HANDLES);

    // Memory enables and address/data between the sequencer and the store.
    mem_ctrl_t            ctrl;
    logic [ID_W-1:0]      pool_rd_addr;
    logic [ID_W-1:0]      pool_wr_addr;
    logic [ID_W-1:0]      pool_wr_data;
    logic [ID_W-1:0]      meta_rd_addr;
    logic [ID_W-1:0]      meta_wr_addr;
    logic [ID_W-1:0]      meta_wr_pos;
    logic [GEN_BITS-1:0]  meta_wr_gen;
    logic [ID_W-1:0]      pool_rd_data;
    logic [ID_W-1:0]      meta_rd_pos;
    logic [GEN_BITS-1:0]  meta_rd_gen;

    // The sequencer owns the live and fresh counters, steps each item through
    // its memory accesses and holds the result until it is taken.
    gha_seq #(
        .MAX_HANDLES (MAX_HANDLES),
        .GEN_BITS    (GEN_BITS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .handle_id    (handle_id),
        .handle_gen   (handle_gen),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .out_id       (out_id),
        .out_gen      (out_gen),
        .live_total   (live_total),
        .ctrl         (ctrl),
        .pool_rd_addr (pool_rd_addr),
        .pool_wr_addr (pool_wr_addr),
        .pool_wr_data (pool_wr_data),
        .meta_rd_addr (meta_rd_addr),
        .meta_wr_addr (meta_wr_addr),
        .meta_wr_pos  (meta_wr_pos),
        .meta_wr_gen  (meta_wr_gen),
        .pool_rd_data (pool_rd_data),
        .meta_rd_pos  (meta_rd_pos),
        .meta_rd_gen  (meta_rd_gen)
    );

    // The store holds the pool and the per-id metadata. All writes of one
    // item land before the next item is taken, so no forwarding is needed.
    gha_store #(
        .DEPTH (MAX_HANDLES),
        .GEN_W (GEN_BITS)
    ) u_store (
        .clk          (clk),
        .ctrl         (ctrl),
        .pool_rd_addr (pool_rd_addr),
        .pool_wr_addr (pool_wr_addr),
        .pool_wr_data (pool_wr_data),
        .meta_rd_addr (meta_rd_addr),
        .meta_wr_addr (meta_wr_addr),
        .meta_wr_pos  (meta_wr_pos),
        .meta_wr_gen  (meta_wr_gen),
        .pool_rd_data (pool_rd_data),
        .meta_rd_pos  (meta_rd_pos),
        .meta_rd_gen  (meta_rd_gen)
    );

endmodule

>>> hdl/gha_checker.sv
// ============================================================================
// gha_checker
// Port-level checks of the generational handle allocator, bound to its top.
// ============================================================================
module gha_checker
    import gha_pkg::*;
#(
    parameter int MAX_HANDLES = DEF_MAX_HANDLES,
    parameter int GEN_BITS    = DEF_GEN_BITS
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic                             kind,
    input  logic [$clog2(MAX_HANDLES)-1:0]   handle_id,
    input  logic [GEN_BITS-1:0]              handle_gen,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [1:0]                       status,
    input  logic [$clog2(MAX_HANDLES)-1:0]   out_id,
    input  logic [GEN_BITS-1:0]              out_gen,
    input  logic [$clog2(MAX_HANDLES+1)-1:0] live_total
);

    localparam int COUNT_W = $clog2(MAX_HANDLES + 1);

    // A stalled input item stays on the wires unchanged.
    property p_item_holds;
        @(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(kind) && $stable(handle_id)
            && $stable(handle_gen);
    endproperty
    a_item_holds: assert property (p_item_holds)
        else $error("stalled input item changed");

    // A stalled result holds its value.
    property p_result_holds;
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_id)
            && $stable(out_gen) && $stable(live_total);
    endproperty
    a_result_holds: assert property (p_result_holds)
        else $error("stalled result changed");

    // Only a create returns a handle; every other result has zero id and gen.
    property p_zero_handle;
        @(posedge clk) disable iff (!rst_n)
        out_valid && status != STAT_CREATED |-> out_id == '0 && out_gen == '0;
    endproperty
    a_zero_handle: assert property (p_zero_handle)
        else $error("non-create result carries a handle");

    // A successful create leaves at least one live handle.
    property p_create_live;
        @(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_CREATED |-> live_total != '0;
    endproperty
    a_create_live: assert property (p_create_live)
        else $error("create reported with no live handle");

    // The pool is only full when every id is live.
    property p_full_count;
        @(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_FULL |-> live_total == COUNT_W'(MAX_HANDLES);
    endproperty
    a_full_count: assert property (p_full_count)
        else $error("pool full reported below capacity");

endmodule

bind generational_handle_allocator gha_checker #(
    .MAX_HANDLES (MAX_HANDLES),
    .GEN_BITS    (GEN_BITS)
) u_gha_checker (.*);
